// File: rtl/periodic_task_release_scheduler_top_assert.svh
// assertion macros for the periodic task release scheduler
// expects signals named clock and reset in the using module
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_TOP_ASSERT_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define PTS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// next-cycle implication
`define PTS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

// File: rtl/pts_pkg.sv
// shared types and constants of the periodic task release scheduler
// no dependencies
package pts_pkg;

   localparam int DATA_W        = 16;
   localparam int NUM_SLOTS_DEF = 16;
   localparam int POS_W         = 6;

   localparam logic [2:0] CMD_CREATE   = 3'd0;
   localparam logic [2:0] CMD_START    = 3'd1;
   localparam logic [2:0] CMD_DELETE   = 3'd2;
   localparam logic [2:0] CMD_SUSPEND  = 3'd3;
   localparam logic [2:0] CMD_RESUME   = 3'd4;
   localparam logic [2:0] CMD_TICK     = 3'd5;
   localparam logic [2:0] CMD_SCHEDULE = 3'd6;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NOT_OPEN    = 2'd1;
   localparam logic [1:0] ST_STARTED     = 2'd2;
   localparam logic [1:0] ST_NOT_LISTED  = 2'd3;

   localparam int MARK_OPEN    = 0;
   localparam int MARK_SUSPEND = 1;
   localparam int MARK_RUN     = 2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ROT,
      CELL_INS,
      CELL_DEL
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [POS_W-1:0] pos;
   } cell_ctl_type;

endpackage

// File: rtl/pts_cell.sv
// one position of the start list, holds a slot index
// depends on pts_pkg
module pts_cell import pts_pkg::*; #(
   parameter int SW  = 4,
   parameter int IDX = 0
) (
   input  logic          clock,
   input  cell_ctl_type  ctl,
   input  logic [SW-1:0] left_id,
   input  logic [SW-1:0] right_id,
   input  logic [SW-1:0] load_id,
   output logic [SW-1:0] id
);

   localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

   logic [SW-1:0] id_ff;
   logic [SW-1:0] id_in;

   always_comb begin
      id_in = id_ff;
      case (ctl.op)
         CELL_ROT: id_in = right_id;
         CELL_INS: begin
            if (MY_POS > ctl.pos) id_in = left_id;
            else if (MY_POS == ctl.pos) id_in = load_id;
         end
         CELL_DEL: begin
            if (MY_POS >= ctl.pos) id_in = right_id;
         end
         default: id_in = id_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id = id_ff;

endmodule

// File: rtl/pts_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on pts_pkg
module pts_div import pts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic [DATA_W-1:0] quotient,
   output logic [DATA_W-1:0] remainder,
   output logic              done,
   output logic              busy
);

   localparam int CNT_W = $clog2(DATA_W + 1);

   logic [DATA_W-1:0] rem_ff, quo_ff, dsr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, done_ff;
   logic [DATA_W:0]   shifted, diff;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = !diff[DATA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsr_ff  <= divisor;
            cnt_ff  <= CNT_W'(DATA_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;
   assign busy      = busy_ff;

endmodule

// File: rtl/periodic_task_release_scheduler_top.sv
// periodic task release scheduler: slot table, chain of list cells, serial divider
// depends on pts_pkg, pts_cell, pts_div and the assertion macro header
// one item at a time; delete makes a second walk that refreshes max
// schedule may also wait on rsp_stall; output register frees the input
// synchronous reset clears slot table, list count, tick counter, max period; base period = 1
`include "periodic_task_release_scheduler_top_assert.svh"

module periodic_task_release_scheduler_top import pts_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_cmd,
   input  logic [3:0]        req_slot,
   input  logic [DATA_W-1:0] req_period_ms,
   input  logic [7:0]        req_prio,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_task_id,
   output logic [1:0]        rsp_status,
   output logic              rsp_dispatched,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [DATA_W-1:0] csr_data
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int IW = (SW > 4) ? SW : 4;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_DEC, S_WA, S_WB, S_TB, S_DQ, S_DR, S_INS, S_DEL, S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      W_SEARCH, W_MAX, W_TICK, W_SCHED
   } walk_type;

   // slot table, one write and one registered read per cycle
   logic [DATA_W-1:0] per_mem [NUM_SLOTS];
   logic [7:0]        prio_mem [NUM_SLOTS];
   logic [2:0]        marks_mem [NUM_SLOTS];

   state_type         state_ff;
   walk_type          walk_ff;
   logic [2:0]        cmd_ff;
   logic [3:0]        slot_ff;
   logic [DATA_W-1:0] my_per_ff, rd_per_ff, tick_ff, max_ff, base_ff, bound_ff, acc_ff;
   logic [7:0]        my_prio_ff, rd_prio_ff;
   logic [2:0]        rd_marks_ff;
   logic [CW-1:0]     cnt_ff, k_ff, pos_ff, fpos_ff;
   logic              found_ff, posset_ff, pend_v_ff;
   logic [SW-1:0]     pend_id_ff;
   logic [3:0]        res_id_ff;
   logic [1:0]        res_st_ff;
   logic              res_disp_ff;
   logic              rsp_valid_ff, rsp_dispatched_ff, rsp_last_ff;
   logic [3:0]        rsp_task_id_ff;
   logic [1:0]        rsp_status_ff;
   logic              div_start_ff;
   logic [DATA_W-1:0] div_a_ff, div_b_ff;

   logic [DATA_W-1:0] div_q, div_r, q_eff, base_eff;
   logic              div_done, div_busy;
   logic [SW-1:0]     cell_id [NUM_SLOTS];
   logic [SW-1:0]     head, sidx, req_sidx;
   logic              listed, walk_end, out_free, sched_hit, sched_emit, adv, out_load;
   logic              req_in_range, slot_in_range;
   logic [IW-1:0]     pend_w;
   cell_ctl_type      cell_ctl;
   logic [3:0]        out_id;
   logic [1:0]        out_st;
   logic              out_disp, out_last;

   // list cells: position 0 is the head, rotation walks the list in order
   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      pts_cell #(.SW(SW), .IDX(g)) u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .left_id  (cell_id[(g + NUM_SLOTS - 1) % NUM_SLOTS]),
         .right_id (cell_id[(g + 1) % NUM_SLOTS]),
         .load_id  (sidx),
         .id       (cell_id[g])
      );
   end

   pts_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (div_a_ff),
      .divisor   (div_b_ff),
      .quotient  (div_q),
      .remainder (div_r),
      .done      (div_done),
      .busy      (div_busy)
   );

   assign head          = cell_id[0];
   assign sidx          = SW'(slot_ff);
   assign req_sidx      = SW'(req_slot);
   assign slot_in_range = 32'(slot_ff) < NUM_SLOTS;
   assign req_in_range  = 32'(req_slot) < NUM_SLOTS;
   assign listed        = k_ff < cnt_ff;
   assign walk_end      = k_ff == CW'(NUM_SLOTS);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign base_eff      = (base_ff == '0) ? DATA_W'(1) : base_ff;
   // a zero quotient counts as one
   assign q_eff         = (div_q == '0) ? DATA_W'(1) : div_q;
   assign pend_w        = IW'(pend_id_ff);

   // released slot found while walking for schedule
   assign sched_hit  = (state_ff == S_WB) && (walk_ff == W_SCHED) && listed
                       && rd_marks_ff[MARK_RUN];
   assign sched_emit = sched_hit && pend_v_ff;

   always_comb begin
      adv = 1'b0;
      if (state_ff == S_WB) begin
         case (walk_ff)
            W_TICK:  adv = !listed;
            W_SCHED: adv = !sched_emit || out_free;
            default: adv = 1'b1;
         endcase
      end else if (state_ff == S_DR) begin
         adv = div_done;
      end
   end

   always_comb begin
      cell_ctl.op  = CELL_HOLD;
      cell_ctl.pos = POS_W'(pos_ff);
      if (adv) begin
         cell_ctl.op = CELL_ROT;
      end else if (state_ff == S_INS) begin
         cell_ctl.op = CELL_INS;
      end else if (state_ff == S_DEL) begin
         cell_ctl.op  = CELL_DEL;
         cell_ctl.pos = POS_W'(fpos_ff);
      end
   end

   // results leave through one output register
   assign out_load = ((state_ff == S_EMIT) && out_free) || (sched_emit && out_free);

   always_comb begin
      if (state_ff == S_EMIT) begin
         out_id   = res_id_ff;
         out_st   = res_st_ff;
         out_disp = res_disp_ff;
         out_last = 1'b1;
      end else begin
         out_id   = pend_w[3:0];
         out_st   = ST_OK;
         out_disp = 1'b1;
         out_last = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         walk_ff      <= W_SEARCH;
         cnt_ff       <= '0;
         tick_ff      <= '0;
         max_ff       <= '0;
         base_ff      <= DATA_W'(1);
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            per_mem[i]   <= '0;
            prio_mem[i]  <= '0;
            marks_mem[i] <= '0;
         end
      end else begin
         div_start_ff <= 1'b0;
         if (csr_valid) base_ff <= csr_data;
         if (out_load) begin
            rsp_valid_ff      <= 1'b1;
            rsp_task_id_ff    <= out_id;
            rsp_status_ff     <= out_st;
            rsp_dispatched_ff <= out_disp;
            rsp_last_ff       <= out_last;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (adv) k_ff <= k_ff + CW'(1);

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff      <= req_cmd;
                  slot_ff     <= req_slot;
                  k_ff        <= '0;
                  acc_ff      <= '0;
                  found_ff    <= 1'b0;
                  posset_ff   <= 1'b0;
                  pos_ff      <= cnt_ff;
                  pend_v_ff   <= 1'b0;
                  res_id_ff   <= req_slot;
                  res_st_ff   <= ST_OK;
                  res_disp_ff <= 1'b0;
                  case (req_cmd)
                     CMD_TICK: begin
                        tick_ff      <= tick_ff + DATA_W'(1);
                        div_a_ff     <= max_ff;
                        div_b_ff     <= base_eff;
                        div_start_ff <= 1'b1;
                        walk_ff      <= W_TICK;
                        state_ff     <= S_TB;
                     end
                     CMD_SCHEDULE: begin
                        walk_ff  <= W_SCHED;
                        state_ff <= S_WA;
                     end
                     CMD_CREATE, CMD_START, CMD_DELETE, CMD_SUSPEND, CMD_RESUME: begin
                        if (!req_in_range) begin
                           res_st_ff <= ST_NOT_OPEN;
                           state_ff  <= S_EMIT;
                        end else if (req_cmd == CMD_CREATE) begin
                           per_mem[req_sidx]   <= req_period_ms;
                           prio_mem[req_sidx]  <= req_prio;
                           marks_mem[req_sidx] <= 3'b001;
                           state_ff            <= S_EMIT;
                        end else begin
                           state_ff <= S_RD;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_RD: begin
               rd_per_ff   <= per_mem[sidx];
               rd_prio_ff  <= prio_mem[sidx];
               rd_marks_ff <= marks_mem[sidx];
               state_ff    <= S_DEC;
            end
            S_DEC: begin
               my_per_ff  <= rd_per_ff;
               my_prio_ff <= rd_prio_ff;
               case (cmd_ff)
                  CMD_START: begin
                     walk_ff  <= W_SEARCH;
                     state_ff <= S_WA;
                  end
                  CMD_DELETE: begin
                     if (!rd_marks_ff[MARK_OPEN]) begin
                        res_st_ff <= ST_NOT_OPEN;
                        state_ff  <= S_EMIT;
                     end else begin
                        marks_mem[sidx] <= '0;
                        walk_ff         <= W_SEARCH;
                        state_ff        <= S_WA;
                     end
                  end
                  CMD_SUSPEND: begin
                     if (!rd_marks_ff[MARK_OPEN]) begin
                        res_st_ff <= ST_NOT_OPEN;
                        state_ff  <= S_EMIT;
                     end else begin
                        marks_mem[sidx] <= rd_marks_ff | 3'b010;
                        walk_ff         <= W_MAX;
                        state_ff        <= S_WA;
                     end
                  end
                  default: begin
                     if (!rd_marks_ff[MARK_OPEN]) res_st_ff <= ST_NOT_OPEN;
                     else marks_mem[sidx] <= rd_marks_ff & 3'b101;
                     state_ff <= S_EMIT;
                  end
               endcase
            end
            S_WA: begin
               if (!walk_end) begin
                  rd_per_ff   <= per_mem[head];
                  rd_prio_ff  <= prio_mem[head];
                  rd_marks_ff <= marks_mem[head];
                  state_ff    <= S_WB;
               end else begin
                  // whole chain rotated back to its original order
                  case (walk_ff)
                     W_SEARCH: begin
                        if (cmd_ff == CMD_START) begin
                           if (found_ff || (cnt_ff == CW'(NUM_SLOTS))) begin
                              res_st_ff <= ST_STARTED;
                              state_ff  <= S_EMIT;
                           end else begin
                              state_ff <= S_INS;
                           end
                        end else if (!found_ff) begin
                           res_st_ff <= ST_NOT_LISTED;
                           state_ff  <= S_EMIT;
                        end else begin
                           state_ff <= S_DEL;
                        end
                     end
                     W_MAX: begin
                        max_ff   <= acc_ff;
                        state_ff <= S_EMIT;
                     end
                     W_TICK: begin
                        if (tick_ff >= bound_ff) tick_ff <= '0;
                        res_id_ff <= '0;
                        state_ff  <= S_EMIT;
                     end
                     default: begin
                        res_id_ff   <= pend_v_ff ? pend_w[3:0] : 4'd0;
                        res_disp_ff <= pend_v_ff;
                        state_ff    <= S_EMIT;
                     end
                  endcase
               end
            end
            S_WB: begin
               case (walk_ff)
                  W_SEARCH: begin
                     if (listed && (head == sidx)) begin
                        found_ff <= 1'b1;
                        fpos_ff  <= k_ff;
                     end
                     // first listed entry of lower priority is the insertion point
                     if (listed && !posset_ff && (rd_prio_ff < my_prio_ff)) begin
                        posset_ff <= 1'b1;
                        pos_ff    <= k_ff;
                     end
                  end
                  W_MAX: begin
                     if (listed && !rd_marks_ff[MARK_SUSPEND] && (rd_per_ff > acc_ff))
                        acc_ff <= rd_per_ff;
                  end
                  W_TICK: begin
                     if (listed) begin
                        div_a_ff     <= rd_per_ff;
                        div_b_ff     <= base_eff;
                        div_start_ff <= 1'b1;
                        state_ff     <= S_DQ;
                     end
                  end
                  default: begin
                     if (sched_hit && adv) begin
                        marks_mem[head] <= rd_marks_ff & 3'b011;
                        pend_id_ff      <= head;
                        pend_v_ff       <= 1'b1;
                     end
                  end
               endcase
               if (adv) state_ff <= S_WA;
            end
            S_TB: begin
               if (div_done) begin
                  bound_ff <= div_q;
                  state_ff <= S_WA;
               end
            end
            S_DQ: begin
               if (div_done) begin
                  if (q_eff > bound_ff) bound_ff <= q_eff;
                  div_a_ff     <= tick_ff;
                  div_b_ff     <= q_eff;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DR;
               end
            end
            S_DR: begin
               if (div_done) begin
                  // release when the quotient divides the counter and the slot is not suspended
                  if ((div_r == '0) && !rd_marks_ff[MARK_SUSPEND])
                     marks_mem[head] <= rd_marks_ff | 3'b100;
                  state_ff <= S_WA;
               end
            end
            S_INS: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (my_per_ff > max_ff) max_ff <= my_per_ff;
               state_ff <= S_EMIT;
            end
            S_DEL: begin
               cnt_ff   <= cnt_ff - CW'(1);
               k_ff     <= '0;
               acc_ff   <= '0;
               walk_ff  <= W_MAX;
               state_ff <= S_WA;
            end
            S_EMIT: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall      = state_ff != S_IDLE;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_task_id    = rsp_task_id_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_dispatched = rsp_dispatched_ff;
   assign rsp_last       = rsp_last_ff;

   // slot range is checked at accept, the latched copy must agree
   `PTS_ASSERT_IMP(a_range_seen, (state_ff == S_DEC), slot_in_range)
   `PTS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= CW'(NUM_SLOTS))
   `PTS_ASSERT_IMP(a_div_idle, div_start_ff, !div_busy)
   `PTS_ASSERT_IMP(a_out_free, out_load, out_free)

endmodule
